/* src/tdpt_pkg.sv */
// Shared widths and defaults for the trial-division prime test.
`default_nettype none
package tdpt_pkg;
  localparam int CAND_W    = 32;
  localparam int DEF_WIDTH = 32;
  localparam int MIN_WIDTH = 8;
  localparam int MAX_WIDTH = 64;
endpackage
`default_nettype wire

/* src/tdpt_ifs.sv */
// Valid/ready stream interfaces for candidate and result beats.
`default_nettype none
interface tdpt_cand_if;
  import tdpt_pkg::*;
  logic              valid;
  logic              ready;
  logic [CAND_W-1:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

/* src/trial_division_prime_test.sv */
// Trial-division primality test built around one shared restoring divider.
//
// Each candidate beat gives exactly one result beat. The candidate is masked to
// WIDTH bits. Values below four and even values are decided at the edge that
// takes the beat, and their result beat is offered from S_FIN once the output
// register is free. Any other value is divided by 3, 5, 7, ... in a shared
// restoring divider that produces one quotient bit per cycle, so each trial
// divisor takes WIDTH divide steps in S_DIV and one check in S_CHECK, and S_FIN
// then loads the output register once it is free. A composite stops at its
// smallest odd factor. The block takes no new candidate while a test is running;
// a finished result waits in the output register while the next candidate is accepted.
`default_nettype none
module trial_division_prime_test #(
  parameter int WIDTH = tdpt_pkg::DEF_WIDTH
) (
  input  wire          clk,
  input  wire          rst,
  tdpt_cand_if.sink    req,
  tdpt_res_if.source   rsp
);
  import tdpt_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);
  localparam int NB    = (WIDTH < CAND_W) ? WIDTH : CAND_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]       state;
  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] d;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic             res;
  logic             out_valid;
  logic             out_prime;

  logic [WIDTH-1:0] n_in;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  always_comb begin
    n_in = '0;
    for (int i = 0; i < NB; i++) begin
      n_in[i] = req.candidate[i];
    end
  end

  // One restoring step: bring in the next dividend bit and try to subtract.
  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, d};

  assign req.ready    = (state == S_IDLE);
  assign rsp.valid    = out_valid;
  assign rsp.is_prime = out_prime;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // In S_FIN the output register is reloaded below instead.
      if (out_valid && rsp.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            n <= n_in;
            if (n_in[WIDTH-1:1] == '0) begin
              res   <= 1'b0;
              state <= S_FIN;
            end else if (n_in[WIDTH-1:2] == '0) begin
              res   <= 1'b1;
              state <= S_FIN;
            end else if (!n_in[0]) begin
              res   <= 1'b0;
              state <= S_FIN;
            end else begin
              d     <= WIDTH'(3);
              quo   <= n_in;
              rem   <= '0;
              cnt   <= CNT_W'(WIDTH - 1);
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (!diff[WIDTH]) begin
            rem <= diff[WIDTH-1:0];
            quo <= {quo[WIDTH-2:0], 1'b1};
          end else begin
            rem <= shifted[WIDTH-1:0];
            quo <= {quo[WIDTH-2:0], 1'b0};
          end
          if (cnt == '0) begin
            state <= S_CHECK;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_CHECK: begin
          // The divisor has passed the square root once it exceeds n / d.
          if (d > quo) begin
            res   <= 1'b1;
            state <= S_FIN;
          end else if (rem == '0) begin
            res   <= 1'b0;
            state <= S_FIN;
          end else begin
            d     <= d + WIDTH'(2);
            quo   <= n;
            rem   <= '0;
            cnt   <= CNT_W'(WIDTH - 1);
            state <= S_DIV;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_prime <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

/* src/tdpt_checker.sv */
// Port-level checks for the trial-division prime test, bound to the top level.
`default_nettype none
module tdpt_checker (
  input wire clk,
  input wire rst,
  input wire req_valid,
  input wire req_ready,
  input wire rsp_valid,
  input wire rsp_ready,
  input wire is_prime
);
  // A result beat that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result beat dropped before it was taken");

  // A result beat that is not taken keeps its value.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(is_prime))
    else $error("result value changed while stalled");

  // Once a candidate is taken, the block is busy with it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("candidate accepted while a test was running");

  // A new result only appears when a test has just finished.
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a finished test");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result offered right after reset");
endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .is_prime  (rsp.is_prime)
);
`default_nettype wire

/* dv/prime_checker.sv */
// Checker for the prime test: watches both streams, predicts each verdict and compares.
module prime_checker #(
  parameter int WIDTH = tdpt_pkg::DEF_WIDTH
) (
  input  logic  clk,
  input  logic  rst,
  tdpt_cand_if  cand,
  tdpt_res_if   res,
  output int    errors,
  output int    pending,
  output int    checked,
  output int    primes
);
  import tdpt_pkg::*;

  bit due_verdicts[$];
  int fail_count;
  int verdict_count;
  int prime_count;
  bit want;

  // Trial division by odd divisors; the bound d <= n / d avoids squaring.
  function automatic bit prime_by_division(logic [CAND_W-1:0] raw);
    longint unsigned mask;
    longint unsigned n;
    longint unsigned d;
    mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
    n = longint'(raw) & mask;
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (n[0] == 1'b0) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic note_failure(string what, logic got, bit wanted);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch: %s, is_prime got %b expected %b", $realtime, what, got,
               wanted);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // Push before pop so that the oldest expectation is always at the front.
      if (cand.valid && cand.ready) begin
        due_verdicts.insert(due_verdicts.size(), prime_by_division(cand.candidate));
      end
      if (res.valid && res.ready) begin
        if (due_verdicts.size() == 0) begin
          note_failure("result beat with nothing outstanding", res.is_prime, 1'b0);
        end else begin
          want = due_verdicts[0];
          due_verdicts.delete(0);
          verdict_count++;
          if (want) prime_count++;
          if (res.is_prime !== want) begin
            note_failure("wrong verdict", res.is_prime, want);
          end
        end
      end
    end
    errors  <= fail_count;
    pending <= due_verdicts.size();
    checked <= verdict_count;
    primes  <= prime_count;
  end

endmodule

/* dv/tb_top.sv */
// Top of the prime test bench: clock, reset, candidate stimulus, result back-pressure, verdict.
module tb_top;
  import tdpt_pkg::*;

  logic clk;
  logic rst;
  bit   calm;
  int   errors;
  int   pending;
  int   checked;
  int   primes;
  int   directed_count;
  int   random_count;

  tdpt_cand_if cand_bus ();
  tdpt_res_if  res_bus ();

  trial_division_prime_test #(.WIDTH(DEF_WIDTH)) dut (
    .clk (clk),
    .rst (rst),
    .req (cand_bus),
    .rsp (res_bus)
  );

  prime_checker #(.WIDTH(DEF_WIDTH)) checker_i (
    .clk     (clk),
    .rst     (rst),
    .cand    (cand_bus),
    .res     (res_bus),
    .errors  (errors),
    .pending (pending),
    .checked (checked),
    .primes  (primes)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog with wide margin over the longest test, that of a largest 32-bit prime.
  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk) begin
    res_bus.ready <= calm || ($urandom_range(99) >= 12);
  end

  task automatic offer_candidate(input logic [CAND_W-1:0] value);
    int gap;
    if (!calm && $urandom_range(99) < 12) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      cand_bus.valid     <= 1'b0;
      cand_bus.candidate <= $urandom();
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cand_bus.valid     <= 1'b1;
    cand_bus.candidate <= value;
    @(posedge clk);
    while (!cand_bus.ready) @(posedge clk);
  endtask

  // Mostly small values keep the run short; wide values are even or carry a small odd factor.
  function automatic logic [CAND_W-1:0] random_candidate();
    int unsigned pick;
    int unsigned factor;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom_range(255, 0);
    if (pick < 70) return $urandom_range(65535, 256);
    if (pick < 80) return $urandom_range(1 << 20, 65536);
    if (pick < 90) return $urandom() & ~32'd1;
    factor = $urandom_range(15, 3) | 1;
    return ($urandom() / factor) * factor;
  endfunction

  initial begin
    logic [CAND_W-1:0] directed[$];
    directed = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
      32'd97, 32'd121, 32'd169, 32'd1042441, 32'd65535, 32'd65536, 32'd65537,
      32'd16777213, 32'h5555_5555, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
      32'hFFFF_FFFB
    };
    rst                = 1'b1;
    calm               = 1'b0;
    cand_bus.valid     = 1'b0;
    cand_bus.candidate = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      offer_candidate(directed[i]);
      directed_count++;
    end

    for (int i = 0; i < 80; i++) begin
      // A stretch in the middle runs with no idle cycles on either side.
      calm = (i >= 30 && i < 60);
      offer_candidate(random_candidate());
      random_count++;
    end
    calm = 1'b0;

    @(negedge clk);
    cand_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d directed and %0d random candidates, from zero to the top of the range.",
             directed_count, random_count);
    $display("Checked %0d verdicts, %0d of them prime, with %0d mismatches.",
             checked, primes, errors);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
src/tdpt_pkg.sv
src/tdpt_ifs.sv
src/trial_division_prime_test.sv
src/tdpt_checker.sv
dv/prime_checker.sv
dv/tb_top.sv
